### hw/rtl/tfms_pkg.sv
package tfms_pkg;

	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_DRONE  = 2'd1;
	localparam logic [1:0] KIND_TARGET = 2'd2;
	localparam logic [1:0] KIND_ABORT  = 2'd3;

	localparam logic [2:0] MSG_HEARTBEAT = 3'd0;
	localparam logic [2:0] MSG_SETPOINT  = 3'd1;
	localparam logic [2:0] MSG_SETMODE   = 3'd2;
	localparam logic [2:0] MSG_ARM       = 3'd3;
	localparam logic [2:0] MSG_DISARM    = 3'd4;
	localparam logic [2:0] MSG_LAND      = 3'd5;

	localparam logic [2:0] PH_WAIT    = 3'd0;
	localparam logic [2:0] PH_TAKEOFF = 3'd1;
	localparam logic [2:0] PH_TRACK   = 3'd2;
	localparam logic [2:0] PH_LAND    = 3'd3;
	localparam logic [2:0] PH_DONE    = 3'd4;

	localparam logic [2:0] REG_CRUISE    = 3'd0;
	localparam logic [2:0] REG_MIN_DIST  = 3'd1;
	localparam logic [2:0] REG_HYST      = 3'd2;
	localparam logic [2:0] REG_STEP      = 3'd3;
	localparam logic [2:0] REG_TOLERANCE = 3'd4;
	localparam logic [2:0] REG_WARMUP    = 3'd5;

	localparam logic signed [31:0] RST_CRUISE    = -32'sd131072;
	localparam logic [30:0]        RST_MIN_DIST  = 31'd65536;
	localparam logic [30:0]        RST_HYST      = 31'd13107;
	localparam logic [30:0]        RST_STEP      = 31'd52429;
	localparam logic [30:0]        RST_TOLERANCE = 31'd19661;
	localparam logic [7:0]         RST_WARMUP    = 8'd10;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               abort_request;
	} tfms_in_t;

	typedef struct packed {
		logic [2:0]         message_kind;
		logic signed [31:0] set_x;
		logic signed [31:0] set_y;
		logic signed [31:0] set_z;
		logic [2:0]         mission_phase;
		logic               following;
		logic               last;
	} tfms_out_t;

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] d;
		logic signed [31:0] r;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			r = d[32] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			r = d[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [32:0] o);
		logic signed [33:0] d;
		logic signed [31:0] r;
		d = {{2{a[31]}}, a} + {o[32], o};
		if ((d[33] != d[32]) || (d[32] != d[31])) begin
			r = d[33] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			r = d[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag(input logic signed [31:0] x);
		logic [31:0] r;
		r = x[31] ? (~x + 32'd1) : x;
		return r;
	endfunction

endpackage

### hw/rtl/target_follow_mission_sequencer.sv
// target-follow mission sequencer
// input channel (in_valid/in_ready/in_data): one beat per item; drone and
// target positions and aborts update state and return no beat, ticks return
// one to four message beats on the output channel (out_valid/out_ready/
// out_data), the final one flagged with last
// configuration: cfg_we/cfg_index/cfg_data write a register; the user must
// write only while the block is idle, which the block itself does not enforce
// work per tick: a warm-up tick goes straight to its messages; landing,
// waiting and targetless tracking ticks need only the phase step; a
// takeoff or done-phase tick runs four serial multiplies, a tracking tick
// that holds runs two multiplies and a serial square root, and one that
// follows runs two more multiply and divide pairs; position and abort
// items are handled in the idle state
// one item is in work at a time: in_ready is low from a tick until its
// last message beat is taken, and a stalled receiver holds the block there
// reset: registers return to their defaults, phase waiting, positions zero
module target_follow_mission_sequencer import tfms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  tfms_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output tfms_out_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WARM  = 4'd1;
	localparam logic [3:0] S_PHASE = 4'd2;
	localparam logic [3:0] S_RCH   = 4'd3;
	localparam logic [3:0] S_SQ    = 4'd4;
	localparam logic [3:0] S_SQRT  = 4'd5;
	localparam logic [3:0] S_DEC   = 4'd6;
	localparam logic [3:0] S_OFF   = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_DRAIN = 4'd9;

	logic [3:0]         state_q;
	logic               wt_q;
	logic signed [31:0] cruise_q;
	logic [30:0]        min_q, hyst_q, step_cfg_q, tol_q;
	logic [7:0]         warm_q;
	logic [2:0]         phase_q;
	logic               follow_q;
	logic [7:0]         tick_q;
	logic               seen_q;
	logic signed [31:0] dn_q, de_q, dd_q, tn_q, te_q, hn_q, he_q;
	logic [2:0]         kinds_q [4];
	logic [2:0]         cnt_q;
	logic [1:0]         rd_q;
	logic signed [31:0] spx_q, spy_q, spz_q;
	logic [1:0]         rsel_q;
	logic               axis_q;
	logic [63:0]        acc_q;
	logic [31:0]        dist_q;
	logic [31:0]        step_q;

	logic               mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
	logic [31:0]        mul_a, mul_b, root, quo;
	logic [63:0]        mul_p;
	logic signed [31:0] dx, dy, rch_n, rch_e, rch_d, rch_op;
	logic [31:0]        op_mag;
	logic [31:0]        thresh;
	logic               nf, stop;
	logic signed [32:0] off;
	logic signed [31:0] sval;
	logic               last;
	logic               in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DRAIN);

	assign dx = sat_sub(tn_q, dn_q);
	assign dy = sat_sub(te_q, de_q);

	assign rch_n = (phase_q == PH_DONE) ? hn_q : 32'sd0;
	assign rch_e = (phase_q == PH_DONE) ? he_q : 32'sd0;
	assign rch_d = (phase_q == PH_DONE) ? 32'sd0 : cruise_q;

	always_comb begin
		case (rsel_q)
			2'd0:    rch_op = sat_sub(rch_n, dn_q);
			2'd1:    rch_op = sat_sub(rch_e, de_q);
			default: rch_op = sat_sub(rch_d, dd_q);
		endcase
	end

	always_comb begin
		op_mag = 32'd0;
		mul_b  = 32'd0;
		case (state_q)
			S_RCH: begin
				op_mag = (rsel_q == 2'd3) ? {1'b0, tol_q} : mag(rch_op);
				mul_b  = op_mag;
			end
			S_SQ: begin
				op_mag = axis_q ? mag(dy) : mag(dx);
				mul_b  = op_mag;
			end
			S_OFF: begin
				op_mag = axis_q ? mag(dy) : mag(dx);
				mul_b  = step_q;
			end
			default: begin
				op_mag = 32'd0;
				mul_b  = 32'd0;
			end
		endcase
	end
	assign mul_a = op_mag;

	assign mul_start  = ((state_q == S_RCH) || (state_q == S_SQ) || (state_q == S_OFF))
		&& !wt_q;
	assign sqrt_start = (state_q == S_SQRT) && !wt_q;
	assign div_start  = (state_q == S_DIV) && !wt_q;

	assign thresh = {1'b0, min_q} + {1'b0, hyst_q};
	always_comb begin
		nf   = follow_q;
		stop = 1'b0;
		if (!follow_q) begin
			if (dist_q >= thresh) begin
				nf = 1'b1;
			end
		end else if (dist_q < {1'b0, min_q}) begin
			nf   = 1'b0;
			stop = 1'b1;
		end
	end

	assign off  = (axis_q ? dy[31] : dx[31]) ? -{1'b0, quo} : {1'b0, quo};
	assign sval = sat_add(axis_q ? de_q : dn_q, off);

	tfms_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	tfms_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (acc_q),
		.done   (sqrt_done),
		.root   (root)
	);

	tfms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_p),
		.den    (dist_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign last = ({1'b0, rd_q} + 3'd1) == cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wt_q       <= 1'b0;
			cruise_q   <= RST_CRUISE;
			min_q      <= RST_MIN_DIST;
			hyst_q     <= RST_HYST;
			step_cfg_q <= RST_STEP;
			tol_q      <= RST_TOLERANCE;
			warm_q     <= RST_WARMUP;
			phase_q    <= PH_WAIT;
			follow_q   <= 1'b0;
			tick_q     <= '0;
			seen_q     <= 1'b0;
			dn_q       <= '0;
			de_q       <= '0;
			dd_q       <= '0;
			tn_q       <= '0;
			te_q       <= '0;
			hn_q       <= '0;
			he_q       <= '0;
			cnt_q      <= '0;
			rd_q       <= '0;
			rsel_q     <= '0;
			axis_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CRUISE:    cruise_q   <= cfg_data;
					REG_MIN_DIST:  min_q      <= cfg_data[30:0];
					REG_HYST:      hyst_q     <= cfg_data[30:0];
					REG_STEP:      step_cfg_q <= cfg_data[30:0];
					REG_TOLERANCE: tol_q      <= cfg_data[30:0];
					REG_WARMUP:    warm_q     <= cfg_data[7:0];
					default:       ;
				endcase
			end
			if (mul_start || sqrt_start || div_start) begin
				wt_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (in_data.kind)
							KIND_DRONE: begin
								dn_q <= in_data.pos_x;
								de_q <= in_data.pos_y;
								dd_q <= in_data.pos_z;
							end
							KIND_TARGET: begin
								tn_q   <= in_data.pos_y;
								te_q   <= in_data.pos_x;
								seen_q <= 1'b1;
							end
							KIND_ABORT: begin
								if (in_data.abort_request && (phase_q != PH_LAND)
									&& (phase_q != PH_DONE)) begin
									phase_q <= PH_LAND;
								end
							end
							default: begin
								cnt_q   <= 3'd1;
								rd_q    <= '0;
								state_q <= S_WARM;
							end
						endcase
					end
				end
				S_WARM: begin
					if (tick_q < warm_q) begin
						tick_q  <= tick_q + 8'd1;
						cnt_q   <= 3'd2;
						state_q <= S_DRAIN;
					end else begin
						if ((tick_q == warm_q) && (tick_q != 8'd255)
							&& (phase_q != PH_LAND) && (phase_q != PH_DONE)) begin
							tick_q  <= tick_q + 8'd1;
							cnt_q   <= 3'd3;
							phase_q <= PH_TAKEOFF;
						end
						state_q <= S_PHASE;
					end
				end
				S_PHASE: begin
					rsel_q <= '0;
					axis_q <= 1'b0;
					case (phase_q)
						PH_TAKEOFF: begin
							cnt_q   <= cnt_q + 3'd1;
							state_q <= S_RCH;
						end
						PH_TRACK: begin
							if (!seen_q) begin
								cnt_q   <= cnt_q + 3'd1;
								state_q <= S_DRAIN;
							end else begin
								state_q <= S_SQ;
							end
						end
						PH_LAND: begin
							cnt_q   <= cnt_q + 3'd1;
							phase_q <= PH_DONE;
							state_q <= S_DRAIN;
						end
						PH_DONE: state_q <= S_RCH;
						default: state_q <= S_DRAIN;
					endcase
				end
				S_RCH: begin
					if (mul_done) begin
						wt_q <= 1'b0;
						if (rsel_q != 2'd3) begin
							rsel_q <= rsel_q + 2'd1;
						end else begin
							if (acc_q < mul_p) begin
								if (phase_q == PH_TAKEOFF) begin
									hn_q    <= dn_q;
									he_q    <= de_q;
									phase_q <= PH_TRACK;
								end else begin
									cnt_q <= cnt_q + 3'd1;
								end
							end
							state_q <= S_DRAIN;
						end
					end
				end
				S_SQ: begin
					if (mul_done) begin
						wt_q   <= 1'b0;
						axis_q <= 1'b1;
						if (axis_q) begin
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						wt_q    <= 1'b0;
						axis_q  <= 1'b0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					follow_q <= nf;
					if (!nf) begin
						if (stop) begin
							hn_q <= dn_q;
							he_q <= de_q;
						end
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_DRAIN;
					end else if (dist_q == 32'd0) begin
						hn_q    <= dn_q;
						he_q    <= de_q;
						cnt_q   <= cnt_q + 3'd1;
						state_q <= S_DRAIN;
					end else begin
						state_q <= S_OFF;
					end
				end
				S_OFF: begin
					if (mul_done) begin
						wt_q    <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						wt_q <= 1'b0;
						if (!axis_q) begin
							axis_q  <= 1'b1;
							state_q <= S_OFF;
						end else begin
							hn_q    <= dn_q;
							he_q    <= de_q;
							cnt_q   <= cnt_q + 3'd1;
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					if (out_acc) begin
						if (last) begin
							state_q <= S_IDLE;
						end else begin
							rd_q <= rd_q + 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// message queue, accumulator, distance, step and setpoint payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kinds_q[0] <= MSG_HEARTBEAT;
			end
			S_WARM: begin
				if (tick_q < warm_q) begin
					kinds_q[1] <= MSG_SETPOINT;
					spx_q      <= '0;
					spy_q      <= '0;
					spz_q      <= cruise_q;
				end else begin
					kinds_q[1] <= MSG_SETMODE;
					kinds_q[2] <= MSG_ARM;
				end
			end
			S_PHASE: begin
				acc_q <= '0;
				case (phase_q)
					PH_TAKEOFF: begin
						kinds_q[cnt_q[1:0]] <= MSG_SETPOINT;
						spx_q <= '0;
						spy_q <= '0;
						spz_q <= cruise_q;
					end
					PH_TRACK: begin
						kinds_q[cnt_q[1:0]] <= MSG_SETPOINT;
						spx_q <= hn_q;
						spy_q <= he_q;
						spz_q <= cruise_q;
					end
					PH_LAND: kinds_q[cnt_q[1:0]] <= MSG_LAND;
					PH_DONE: kinds_q[cnt_q[1:0]] <= MSG_DISARM;
					default: ;
				endcase
			end
			S_RCH, S_SQ: begin
				if (mul_done && !((state_q == S_RCH) && (rsel_q == 2'd3))) begin
					acc_q <= acc_q + mul_p;
				end
			end
			S_SQRT: begin
				if (sqrt_done) begin
					dist_q <= root;
				end
			end
			S_DEC: begin
				kinds_q[cnt_q[1:0]] <= MSG_SETPOINT;
				spz_q  <= cruise_q;
				step_q <= ({1'b0, step_cfg_q} < dist_q) ? {1'b0, step_cfg_q} : dist_q;
				if (!nf) begin
					spx_q <= stop ? dn_q : hn_q;
					spy_q <= stop ? de_q : he_q;
				end else begin
					spx_q <= dn_q;
					spy_q <= de_q;
				end
			end
			S_DIV: begin
				if (div_done) begin
					if (axis_q) begin
						spy_q <= sval;
					end else begin
						spx_q <= sval;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		out_data.message_kind  = kinds_q[rd_q];
		out_data.set_x         = (kinds_q[rd_q] == MSG_SETPOINT) ? spx_q : 32'sd0;
		out_data.set_y         = (kinds_q[rd_q] == MSG_SETPOINT) ? spy_q : 32'sd0;
		out_data.set_z         = (kinds_q[rd_q] == MSG_SETPOINT) ? spz_q : 32'sd0;
		out_data.mission_phase = phase_q;
		out_data.following     = follow_q;
		out_data.last          = last;
	end

endmodule

### hw/rtl/tfms_mul.sv
module tfms_mul import tfms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [63:0] p
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] a_q;
	logic [63:0] p_q;
	logic [32:0] t;

	assign t = {1'b0, p_q[63:32]} + (p_q[0] ? {1'b0, a_q} : 33'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q <= a;
			p_q <= {32'd0, b};
		end else if (busy_q) begin
			p_q <= {t, p_q[31:1]};
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

### hw/rtl/tfms_sqrt.sv
module tfms_sqrt import tfms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rad,
	output logic        done,
	output logic [31:0] root
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] s_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [34:0] r;
	logic [34:0] trial;
	logic        ge;

	assign r     = {rem_q[32:0], s_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (r >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			s_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			s_q    <= {s_q[61:0], 2'b00};
			rem_q  <= ge ? 34'(r - trial) : r[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### hw/rtl/tfms_div.sv
module tfms_div import tfms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] d_q;
	logic [32:0] sh;
	logic [32:0] diff;
	logic        ge;

	assign sh   = {rem_q, lo_q[31]};
	assign diff = sh - {1'b0, d_q};
	assign ge   = (sh >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= num[63:32];
			lo_q  <= num[31:0];
			d_q   <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : sh[31:0];
			lo_q  <= {lo_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = lo_q;

endmodule

### test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tfms_pkg::*;

	class mission_scoreboard;
		longint cruise;
		longint unsigned min_d, hyst, stp, tol;
		int unsigned warm;
		logic [2:0] ph;
		bit follow;
		int unsigned ticks;
		longint dn, de, dd, tn, te, hn, he;
		bit seen;
		tfms_out_t pending[$];
		tfms_out_t msgs[$];
		int errors, n_items, n_results;

		function new();
			cruise = RST_CRUISE;
			min_d = RST_MIN_DIST;
			hyst = RST_HYST;
			stp = RST_STEP;
			tol = RST_TOLERANCE;
			warm = RST_WARMUP;
			ph = PH_WAIT;
			follow = 0;
			ticks = 0;
			dn = 0; de = 0; dd = 0; tn = 0; te = 0; hn = 0; he = 0;
			seen = 0;
			errors = 0; n_items = 0; n_results = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_CRUISE: cruise = longint'($signed(v));
				REG_MIN_DIST: min_d = v[30:0];
				REG_HYST: hyst = v[30:0];
				REG_STEP: stp = v[30:0];
				REG_TOLERANCE: tol = v[30:0];
				REG_WARMUP: warm = v[7:0];
				default: ;
			endcase
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint unsigned magn(longint v);
			return v < 0 ? longint'(-v) : v;
		endfunction

		function longint unsigned root(longint unsigned s);
			longint unsigned r, b;
			r = 0;
			b = 64'h4000000000000000;
			while (b > s) b >>= 2;
			while (b != 0) begin
				if (s >= r + b) begin
					s -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function bit near(longint a, longint b, longint c);
			longint unsigned x, y, z;
			x = magn(sat32(a - dn));
			y = magn(sat32(b - de));
			z = magn(sat32(c - dd));
			return x * x + y * y + z * z < tol * tol;
		endfunction

		function longint shift_by(longint d, longint unsigned s, longint unsigned span);
			longint unsigned m;
			if (span == 0) return 0;
			m = magn(d) * s / span;
			return d < 0 ? -longint'(m) : longint'(m);
		endfunction

		function void emit(logic [2:0] k, longint x, longint y, longint z);
			tfms_out_t m;
			m = '0;
			m.message_kind = k;
			m.set_x = x[31:0];
			m.set_y = y[31:0];
			m.set_z = z[31:0];
			msgs.push_back(m);
		endfunction

		function void track();
			longint dx, dy;
			longint unsigned ax, ay, span, s;
			dx = sat32(tn - dn);
			dy = sat32(te - de);
			ax = magn(dx);
			ay = magn(dy);
			span = root(ax * ax + ay * ay);
			if (!follow) begin
				if (span >= min_d + hyst) follow = 1;
			end else if (span < min_d) begin
				follow = 0;
				hn = dn;
				he = de;
			end
			if (!follow) begin
				emit(MSG_SETPOINT, hn, he, cruise);
			end else begin
				s = stp < span ? stp : span;
				emit(MSG_SETPOINT, sat32(dn + shift_by(dx, s, span)),
					sat32(de + shift_by(dy, s, span)), cruise);
				hn = dn;
				he = de;
			end
		endfunction

		function void tick();
			emit(MSG_HEARTBEAT, 0, 0, 0);
			if (ticks < warm) begin
				ticks++;
				emit(MSG_SETPOINT, 0, 0, cruise);
			end else begin
				if (ticks == warm && ticks < 255 && ph != PH_LAND && ph != PH_DONE) begin
					ticks++;
					emit(MSG_SETMODE, 0, 0, 0);
					emit(MSG_ARM, 0, 0, 0);
					ph = PH_TAKEOFF;
				end
				case (ph)
					PH_TAKEOFF: begin
						emit(MSG_SETPOINT, 0, 0, cruise);
						if (near(0, 0, cruise)) begin
							hn = dn;
							he = de;
							ph = PH_TRACK;
						end
					end
					PH_TRACK: begin
						if (!seen) emit(MSG_SETPOINT, hn, he, cruise);
						else track();
					end
					PH_LAND: begin
						emit(MSG_LAND, 0, 0, 0);
						ph = PH_DONE;
					end
					PH_DONE: begin
						if (near(hn, he, 0)) emit(MSG_DISARM, 0, 0, 0);
					end
					default: ;
				endcase
			end
		endfunction

		function void note_input(tfms_in_t d);
			n_items++;
			case (d.kind)
				KIND_DRONE: begin
					dn = longint'($signed(d.pos_x));
					de = longint'($signed(d.pos_y));
					dd = longint'($signed(d.pos_z));
				end
				KIND_TARGET: begin
					tn = longint'($signed(d.pos_y));
					te = longint'($signed(d.pos_x));
					seen = 1;
				end
				KIND_ABORT: begin
					if (d.abort_request && ph != PH_LAND && ph != PH_DONE) ph = PH_LAND;
				end
				default: begin
					msgs.delete();
					tick();
					foreach (msgs[i]) begin
						msgs[i].mission_phase = ph;
						msgs[i].following = follow;
						msgs[i].last = (i == msgs.size() - 1);
						pending.push_back(msgs[i]);
					end
				end
			endcase
		endfunction

		function void report(string f, longint unsigned e, longint unsigned g);
			errors++;
			$display("%0t mismatch %s expected %h actual %h", $time, f, e, g);
		endfunction

		function void check(tfms_out_t got);
			tfms_out_t e;
			n_results++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t unexpected beat actual %p", $time, got);
				return;
			end
			e = pending.pop_front();
			if (got.message_kind !== e.message_kind)
				report("message_kind", e.message_kind, got.message_kind);
			if (got.set_x !== e.set_x) report("set_x", e.set_x, got.set_x);
			if (got.set_y !== e.set_y) report("set_y", e.set_y, got.set_y);
			if (got.set_z !== e.set_z) report("set_z", e.set_z, got.set_z);
			if (got.mission_phase !== e.mission_phase)
				report("mission_phase", e.mission_phase, got.mission_phase);
			if (got.following !== e.following) report("following", e.following, got.following);
			if (got.last !== e.last) report("last", e.last, got.last);
		endfunction
	endclass

	localparam int WATCHDOG = 20000;

	logic clk, arst_n, in_valid, in_ready, out_valid, cfg_we;
	logic out_ready = 1'b0;
	tfms_in_t in_data;
	tfms_out_t out_data;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	mission_scoreboard sb = new();
	int snd_idle, rcv_stall;
	bit hold_req;
	int hold_left = 0;
	int quiet = 0;

	target_follow_mission_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check(out_data);
		if (hold_req) begin
			hold_req = 0;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_stall);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("%0t watchdog: no beat for %0d cycles", $time, quiet);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send(tfms_in_t d);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= d;
		do @(posedge clk); while (!in_ready);
		sb.note_input(d);
	endtask

	task automatic settle();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.write_reg(idx, v);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic tfms_in_t item(logic [1:0] k, logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic a);
		tfms_in_t d;
		d.kind = k;
		d.pos_x = x;
		d.pos_y = y;
		d.pos_z = z;
		d.abort_request = a;
		return d;
	endfunction

	function automatic logic [31:0] coord(longint base);
		longint r;
		if ($urandom_range(3) == 0) return $urandom;
		r = $urandom_range(0, 300000);
		return 32'(base + ($urandom_range(1) ? r : -r));
	endfunction

	task automatic random_run(int n);
		int p;
		repeat (n) begin
			p = $urandom_range(99);
			if (p < 45)
				send(item(KIND_TICK, $urandom, $urandom, $urandom, 1'($urandom_range(1))));
			else if (p < 72)
				send(item(KIND_DRONE, coord(sb.tn), coord(sb.te), coord(sb.cruise),
					1'($urandom_range(1))));
			else if (p < 96)
				send(item(KIND_TARGET, coord(sb.dn), coord(sb.de), $urandom,
					1'($urandom_range(1))));
			else
				send(item(KIND_ABORT, $urandom, $urandom, $urandom, 1'b0));
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = REG_CRUISE;
		cfg_data = '0;
		snd_idle = 0;
		rcv_stall = 0;
		hold_req = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// waiting phase, field extremes
		send(item(KIND_TICK, '0, '0, '0, 1'b0));
		send(item(KIND_ABORT, '1, '1, '1, 1'b0));
		send(item(KIND_DRONE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1));
		send(item(KIND_TARGET, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0));
		send(item(KIND_TICK, '1, '1, '1, 1'b1));
		settle();
		write_cfg(REG_CRUISE, RST_CRUISE);
		write_cfg(REG_WARMUP, 32'(sb.ticks + 1));

		// warm-up, arm, takeoff and tracking
		send(item(KIND_DRONE, '0, '0, RST_CRUISE, 1'b0));
		send(item(KIND_TICK, '0, '0, '0, 1'b0));
		send(item(KIND_TICK, '0, '0, '0, 1'b0));
		send(item(KIND_TICK, '0, '0, '0, 1'b0));
		send(item(KIND_TARGET, 32'h00080000, 32'hfff80000, '0, 1'b0));
		send(item(KIND_TICK, '0, '0, '0, 1'b0));
		send(item(KIND_DRONE, 32'h7fffffff, 32'h80000000, RST_CRUISE, 1'b0));
		send(item(KIND_TARGET, 32'h7fffffff, 32'h80000000, '0, 1'b0));
		send(item(KIND_TICK, '0, '0, '0, 1'b0));
		send(item(KIND_DRONE, 32'(sb.tn), 32'(sb.te), RST_CRUISE, 1'b0));
		send(item(KIND_TICK, '0, '0, '0, 1'b0));
		send(item(KIND_DRONE, 32'h80000000, 32'h7fffffff, '0, 1'b0));
		send(item(KIND_TICK, '0, '0, '0, 1'b0));
		settle();

		write_cfg(REG_MIN_DIST, 32'd65536);
		write_cfg(REG_HYST, 32'd13107);
		write_cfg(REG_STEP, 32'd52429);
		write_cfg(REG_TOLERANCE, 32'd19661);
		random_run(80);
		settle();

		snd_idle = 84;
		write_cfg(REG_MIN_DIST, 32'd0);
		write_cfg(REG_HYST, 32'd0);
		write_cfg(REG_STEP, 32'h7fffffff);
		write_cfg(REG_TOLERANCE, 32'h7fffffff);
		write_cfg(REG_CRUISE, 32'h7fffffff);
		random_run(80);
		settle();

		snd_idle = 0;
		rcv_stall = 84;
		write_cfg(REG_MIN_DIST, 32'h7fffffff);
		write_cfg(REG_HYST, 32'h7fffffff);
		write_cfg(REG_STEP, 32'd0);
		write_cfg(REG_TOLERANCE, 32'd0);
		write_cfg(REG_CRUISE, 32'h80000000);
		hold_req = 1;
		random_run(80);
		settle();

		snd_idle = 29;
		rcv_stall = 29;
		write_cfg(REG_MIN_DIST, $urandom_range(0, 200000));
		write_cfg(REG_HYST, $urandom_range(0, 50000));
		write_cfg(REG_STEP, $urandom_range(1, 150000));
		write_cfg(REG_TOLERANCE, $urandom_range(1000, 100000));
		write_cfg(REG_CRUISE, -$urandom_range(0, 600000));
		random_run(80);
		settle();

		// abort, landing, then done with and without a disarm
		snd_idle = 0;
		rcv_stall = 0;
		write_cfg(REG_TOLERANCE, 32'd19661);
		send(item(KIND_ABORT, '0, '0, '0, 1'b1));
		send(item(KIND_TICK, '0, '0, '0, 1'b0));
		random_run(30);
		send(item(KIND_DRONE, 32'(sb.hn), 32'(sb.he), '0, 1'b0));
		send(item(KIND_TICK, '0, '0, '0, 1'b0));
		send(item(KIND_ABORT, '0, '0, '0, 1'b1));
		send(item(KIND_TICK, '0, '0, '0, 1'b0));
		settle();
		write_cfg(REG_WARMUP, 32'd255);
		snd_idle = 29;
		rcv_stall = 29;
		random_run(30);
		settle();

		$display("covered %0d items and %0d message beats over six register settings",
			sb.n_items, sb.n_results);
		$display("ended in phase %0d with %0d ticks counted", sb.ph, sb.ticks);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d errors, %0d beats missing", sb.errors, sb.pending.size());
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
